// File: src/rsh_pkg.sv
// rsh_pkg: shared constants, types and codes for the rgb sharpen stream unit
// no dependencies; imported by every other file of the block except rsh_ram
`default_nettype none

package rsh_pkg;

    // line store geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);

    // field widths
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int ROW_W       = 16;
    localparam int OUT_COL_W   = 11;
    localparam int CFG_WIDTH_W = 12;
    localparam int CFG_HGT_W   = 16;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);

    localparam logic [CFG_WIDTH_W-1:0] RESET_FRAME_WIDTH  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HGT_W-1:0]   RESET_FRAME_HEIGHT = CFG_HGT_W'(480);

    // kernel constants
    localparam logic [CH_W-1:0] PIX_MAX = CH_W'(255);

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int RSV_W      = FIFO_AW + 2;

    // blue in the low byte, red in the high byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // index row*3+col; row 0 oldest, col 2 newest
    typedef t_pixel [8:0] t_window;

    typedef struct packed {
        logic [OUT_COL_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
        logic [CH_W-1:0]      out_blue;
        logic [CH_W-1:0]      out_green;
        logic [CH_W-1:0]      out_red;
        logic                 last_of_run;
    } t_result;

endpackage

`default_nettype wire

// File: src/rsh_ifs.sv
// rsh_pix_if / rsh_res_if: valid-ready channels for input pixels and results
// depends on rsh_pkg for the field widths
`default_nettype none

interface rsh_pix_if;
    import rsh_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink   (input valid, input in_blue, input in_green, input in_red,
                    output ready);
endinterface

interface rsh_res_if;
    import rsh_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_COL_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_red;
    logic                 last_of_run;

    modport source (output valid, output out_col, output out_row, output out_blue,
                    output out_green, output out_red, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_col, input out_row, input out_blue,
                    input out_green, input out_red, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// File: src/rsh_ram.sv
// rsh_ram: generic single-write, single-read ram with registered read data
// no package dependencies
`default_nettype none

module rsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/rsh_sharpen.sv
// rsh_sharpen: 3x3 sharpen kernel on all three channels, saturated to 0..255
// depends on rsh_pkg for the pixel and window types
`default_nettype none

module rsh_sharpen (
    input  wire rsh_pkg::t_window i_win,
    output rsh_pkg::t_pixel       o_pix
);
    import rsh_pkg::*;

    // 9 * center minus the 8 neighbors
    function automatic logic [CH_W-1:0] sharpen_ch(input logic [8:0][CH_W-1:0] taps);
        logic [CH_W+3:0]        pos;
        logic [CH_W+2:0]        neg;
        logic signed [CH_W+4:0] diff;
        logic [CH_W-1:0]        res;
        pos = (CH_W+4)'({taps[4], 3'b000}) + (CH_W+4)'(taps[4]);
        neg = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                neg = neg + (CH_W+3)'(taps[k]);
            end
        end
        diff = signed'((CH_W+5)'(pos)) - signed'((CH_W+5)'(neg));
        if (diff < 0) begin
            res = '0;
        end else if (diff > signed'((CH_W+5)'(PIX_MAX))) begin
            res = PIX_MAX;
        end else begin
            res = diff[CH_W-1:0];
        end
        return res;
    endfunction

    logic [8:0][CH_W-1:0] w_blue;
    logic [8:0][CH_W-1:0] w_green;
    logic [8:0][CH_W-1:0] w_red;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_blue[k]  = i_win[k].blue;
            w_green[k] = i_win[k].green;
            w_red[k]   = i_win[k].red;
        end
        o_pix.blue  = sharpen_ch(w_blue);
        o_pix.green = sharpen_ch(w_green);
        o_pix.red   = sharpen_ch(w_red);
    end

endmodule

`default_nettype wire

// File: src/rgb_sharpen_3x3_stream_unit.sv
// rgb_sharpen_3x3_stream_unit: top level of the 3x3 rgb sharpen stream filter
// depends on rsh_pkg, rsh_pix_if / rsh_res_if, rsh_ram and rsh_sharpen
// path: an input pixel passes stage 1 and stage 2, and its results are offered from the queue
// throughput: one pixel per cycle while the 8-entry queue has room; a pixel yields up to two
//   results, two only on the last column from row 2 on and from column 2 on in the last row;
//   on the last row the single output paces results at one per cycle while the sink is ready
// reset: synchronous active low; clears counters, valid bits and the queue and sets
//   the frame to 640 x 480; the line store is not cleared
`default_nettype none

module rgb_sharpen_3x3_stream_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire rsh_pkg::t_cfg_idx          i_cfg_idx,
    input  wire logic [rsh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rsh_pix_if.sink                         i_pix,
    rsh_res_if.source                       o_res
);
    import rsh_pkg::*;

    // configuration
    logic [CFG_WIDTH_W-1:0] r_cfg_width;
    logic [CFG_HGT_W-1:0]   r_cfg_height;

    // position of the next incoming pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [COL_W-1:0] w_last_col;
    logic [ROW_W-1:0] w_last_row;
    logic             w_accept;
    logic             w_cfg_hit;
    t_pixel           w_px;

    // stage 1: pixel waits for the line store read
    logic             r_s1_valid;
    t_pixel           r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_inner;
    logic             r_s1_border;

    // stage 2: window holds the neighborhood, results go to the queue
    logic             r_s2_valid;
    t_pixel           r_s2_px;
    logic [COL_W-1:0] r_s2_col;
    logic [ROW_W-1:0] r_s2_row;
    logic             r_s2_inner;
    logic             r_s2_border;

    t_window          r_win;
    t_pixel           w_sharp;

    // line store: entry holds {row r-1, row r-2} for its column
    logic [2*PIX_W-1:0] w_ls_rd;
    t_pixel             w_up1;
    t_pixel             w_up2;

    // result queue
    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr;
    logic [FIFO_AW-1:0]     r_rd_ptr;
    logic [FIFO_AW:0]       r_count;
    logic [RSV_W-1:0]       w_reserved;
    t_result                w_res_a;
    t_result                w_res_b;
    t_result                w_head;
    logic                   w_pop;
    logic [1:0]             w_push_cnt;

    // effective last column and row; zero means one, width saturates at the store size
    always_comb begin
        if (r_cfg_width == '0) begin
            w_last_col = '0;
        end else if (32'(r_cfg_width) >= MAX_WIDTH) begin
            w_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last_col = COL_W'(r_cfg_width - 1'b1);
        end
        if (r_cfg_height == '0) begin
            w_last_row = '0;
        end else begin
            w_last_row = ROW_W'(r_cfg_height - 1'b1);
        end
    end

    // each in-flight pixel reserves two queue slots
    assign w_reserved = RSV_W'(r_count) + RSV_W'({r_s1_valid, 1'b0})
                      + RSV_W'({r_s2_valid, 1'b0});
    assign i_pix.ready = (w_reserved <= RSV_W'(FIFO_DEPTH - 2));
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_cfg_hit   = i_cfg_we
                      && (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT);

    assign w_px.blue  = i_pix.in_blue;
    assign w_px.green = i_pix.in_green;
    assign w_px.red   = i_pix.in_red;

    // configuration registers; a write to a frame register starts a new frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_FRAME_WIDTH;
            r_cfg_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[CFG_HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position, wraps at the end of the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (r_col == w_last_col) begin
                r_col <= '0;
                r_row <= (r_row == w_last_row) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_px     <= w_px;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_inner  <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_s1_border <= (r_row == '0) || (r_row == w_last_row)
                        || (r_col == '0) || (r_col == w_last_col);
        end
    end

    // read at the transfer, write back the shifted column in the next cycle, from stage 1
    rsh_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({r_s1_px, w_up1}),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_ls_rd)
    );

    assign w_up1 = w_ls_rd[2*PIX_W-1:PIX_W];
    assign w_up2 = w_ls_rd[PIX_W-1:0];

    // stage 2 capture and window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_s2_px     <= r_s1_px;
            r_s2_col    <= r_s1_col;
            r_s2_row    <= r_s1_row;
            r_s2_inner  <= r_s1_inner;
            r_s2_border <= r_s1_border;
            r_win[0]    <= r_win[1];
            r_win[1]    <= r_win[2];
            r_win[2]    <= w_up2;
            r_win[3]    <= r_win[4];
            r_win[4]    <= r_win[5];
            r_win[5]    <= w_up1;
            r_win[6]    <= r_win[7];
            r_win[7]    <= r_win[8];
            r_win[8]    <= r_s1_px;
        end
    end

    rsh_sharpen u_sharpen (
        .i_win (r_win),
        .o_pix (w_sharp)
    );

    // first result: sharpened interior pixel if any, else the border copy
    always_comb begin
        w_res_b.out_col     = OUT_COL_W'(r_s2_col);
        w_res_b.out_row     = r_s2_row;
        w_res_b.out_blue    = r_s2_px.blue;
        w_res_b.out_green   = r_s2_px.green;
        w_res_b.out_red     = r_s2_px.red;
        w_res_b.last_of_run = 1'b1;
        if (r_s2_inner) begin
            w_res_a.out_col     = OUT_COL_W'(r_s2_col - 1'b1);
            w_res_a.out_row     = r_s2_row - 1'b1;
            w_res_a.out_blue    = w_sharp.blue;
            w_res_a.out_green   = w_sharp.green;
            w_res_a.out_red     = w_sharp.red;
            w_res_a.last_of_run = !r_s2_border;
        end else begin
            w_res_a = w_res_b;
        end
        w_push_cnt = r_s2_valid ? (2'(r_s2_inner) + 2'(r_s2_border)) : 2'd0;
    end

    assign w_head = r_fifo[r_rd_ptr];
    assign w_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (w_push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res_a;
        end
        if (w_push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= w_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_push_cnt);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(w_pop);
            r_count  <= r_count + (FIFO_AW+1)'(w_push_cnt) - (FIFO_AW+1)'(w_pop);
        end
    end

    // output transfer straight from the queue head
    assign o_res.valid       = (r_count != '0);
    assign o_res.out_col     = w_head.out_col;
    assign o_res.out_row     = w_head.out_row;
    assign o_res.out_blue    = w_head.out_blue;
    assign o_res.out_green   = w_head.out_green;
    assign o_res.out_red     = w_head.out_red;
    assign o_res.last_of_run = w_head.last_of_run;

endmodule

`default_nettype wire

// File: tb/sv/rgb_sharpen_3x3_stream_unit_tb.sv
`timescale 1ns / 1ps
// rgb_sharpen_3x3_stream_unit_tb: self-checking bench for the 3x3 rgb sharpen stream unit
// needs rsh_pkg, rsh_pix_if / rsh_res_if and the rgb_sharpen_3x3_stream_unit rtl

module rgb_sharpen_3x3_stream_unit_tb;
    import rsh_pkg::*;

    // how pixel content is made for a phase
    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} t_pix_mode;

    // indexes past the two frame registers, writes there must change nothing
    localparam t_cfg_idx REG_SPARE_A = t_cfg_idx'(2);
    localparam t_cfg_idx REG_SPARE_B = t_cfg_idx'(3);

    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1150;  // pixels in the random phases
    localparam int MAX_PRINTS   = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rsh_pix_if pix_ch ();
    rsh_res_if res_ch ();

    rgb_sharpen_3x3_stream_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // filter state mirrored by the bench
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0] frame_w_reg;
    logic [CFG_HGT_W-1:0]   frame_h_reg;
    t_pixel                 row_mem [0:2*MAX_WIDTH-1];  // two previous rows, ping-pong by row
    t_window                win_regs;                   // 0 oldest row/col, 8 newest
    int unsigned            next_col;
    int unsigned            next_row;

    t_result     sharpened_due[$];    // results still owed by the block, oldest first
    t_pixel      pix_pending[$];      // pixels waiting for the driver
    int unsigned pixels_queued   = 0;
    int unsigned pixels_accepted = 0;
    int          fail_count      = 0;

    logic        pix_xfer = 1'b0;     // input transfer seen at the last rising edge
    bit          idle_on;             // random gaps and stalls on both channels
    int          pix_gap  = 0;
    int          res_stall = 0;
    int          smooth_lvl [3];
    t_pixel      drive_px;
    t_pixel      seen_px;

    // register value zero means one, width saturates at the line store size
    function automatic int unsigned eff_width();
        int unsigned w;
        w = frame_w_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (frame_h_reg == '0) ? 1 : int'(frame_h_reg);
    endfunction

    // 9 * center minus the 8 neighbors, clamped to a byte
    function automatic logic [CH_W-1:0] sharpen_byte(input t_window wv, input int ch);
        int               acc;
        int               k;
        logic [PIX_W-1:0] pv;
        acc = 0;
        for (k = 0; k < 9; k++) begin
            pv  = wv[k];
            acc = acc - int'(pv[ch*CH_W +: CH_W]);
        end
        pv  = wv[4];
        acc = acc + 10 * int'(pv[ch*CH_W +: CH_W]);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return CH_W'(acc);
    endfunction

    // advance the mirrored filter by one accepted pixel and queue what it causes
    task automatic sharpen_step(input t_pixel px);
        int unsigned w, h, c, r, cur, prv;
        t_pixel      up1, up2;
        t_result     res;
        bit          inner, border;
        w = eff_width();
        h = eff_height();
        c = next_col;
        r = next_row;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        // even rows use the low half of the store, odd rows the high half
        cur = (r % 2) * MAX_WIDTH + c;
        prv = ((r + 1) % 2) * MAX_WIDTH + c;
        up2 = row_mem[cur];
        up1 = row_mem[prv];
        row_mem[cur] = px;
        win_regs[0] = win_regs[1]; win_regs[1] = win_regs[2]; win_regs[2] = up2;
        win_regs[3] = win_regs[4]; win_regs[4] = win_regs[5]; win_regs[5] = up1;
        win_regs[6] = win_regs[7]; win_regs[7] = win_regs[8]; win_regs[8] = px;
        inner  = (c >= 2 && r >= 2);
        border = (r == 0 || r == h - 1 || c == 0 || c == w - 1);
        // the pixel up and to the left is complete: sharpened result goes first
        if (inner) begin
            res.out_col     = OUT_COL_W'(c - 1);
            res.out_row     = ROW_W'(r - 1);
            res.out_blue    = sharpen_byte(win_regs, 0);
            res.out_green   = sharpen_byte(win_regs, 1);
            res.out_red     = sharpen_byte(win_regs, 2);
            res.last_of_run = !border;
            sharpened_due.push_back(res);
        end
        // a border pixel is copied through as it arrives
        if (border) begin
            res.out_col     = OUT_COL_W'(c);
            res.out_row     = ROW_W'(r);
            res.out_blue    = px.blue;
            res.out_green   = px.green;
            res.out_red     = px.red;
            res.last_of_run = 1'b1;
            sharpened_due.push_back(res);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result();
        t_result want;
        if (sharpened_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result at col %0d row %0d",
                                      res_ch.out_col, res_ch.out_row));
        end else begin
            want = sharpened_due.pop_front();
            if (res_ch.out_col !== want.out_col)
                report_mismatch($sformatf("out_col %0d, want %0d (row %0d)",
                                          res_ch.out_col, want.out_col, want.out_row));
            if (res_ch.out_row !== want.out_row)
                report_mismatch($sformatf("out_row %0d, want %0d (col %0d)",
                                          res_ch.out_row, want.out_row, want.out_col));
            if (res_ch.out_blue !== want.out_blue)
                report_mismatch($sformatf("out_blue %0d, want %0d at col %0d row %0d",
                                          res_ch.out_blue, want.out_blue,
                                          want.out_col, want.out_row));
            if (res_ch.out_green !== want.out_green)
                report_mismatch($sformatf("out_green %0d, want %0d at col %0d row %0d",
                                          res_ch.out_green, want.out_green,
                                          want.out_col, want.out_row));
            if (res_ch.out_red !== want.out_red)
                report_mismatch($sformatf("out_red %0d, want %0d at col %0d row %0d",
                                          res_ch.out_red, want.out_red,
                                          want.out_col, want.out_row));
            if (res_ch.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0b, want %0b at col %0d row %0d",
                                          res_ch.last_of_run, want.last_of_run,
                                          want.out_col, want.out_row));
        end
    endtask

    // mostly no gap, some short ones, a rare long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        else if (pick < 88) return $urandom_range(1, 3);
        else if (pick < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] clamp_byte(input int v);
        if (v < 0) return '0;
        if (v > 255) return PIX_MAX;
        return CH_W'(v);
    endfunction

    function automatic t_pixel make_pixel(input t_pix_mode mode);
        logic [PIX_W-1:0] pv;
        int               ch;
        for (ch = 0; ch < 3; ch++) begin
            case (mode)
                PIX_EXTREME: begin
                    // hard edges drive the sum into both clamps
                    if ($urandom_range(0, 9) == 0)
                        pv[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
                    else
                        pv[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? PIX_MAX : '0;
                end
                PIX_SMOOTH: begin
                    // slowly drifting level with a rare jump keeps sums mid-range
                    if ($urandom_range(0, 19) == 0)
                        smooth_lvl[ch] = $urandom_range(0, 255);
                    else
                        smooth_lvl[ch] = clamp_byte(smooth_lvl[ch] +
                                                    int'($urandom_range(0, 8)) - 4);
                    pv[ch*CH_W +: CH_W] = clamp_byte(smooth_lvl[ch] +
                                                     int'($urandom_range(0, 6)) - 3);
                end
                default: pv[ch*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
            endcase
        end
        return t_pixel'(pv);
    endfunction

    task automatic push_pixel(input logic [CH_W-1:0] b, g, r);
        pix_pending.push_back('{red: r, green: g, blue: b});
        pixels_queued++;
    endtask

    task automatic queue_pixels(input int n, input t_pix_mode mode);
        int i;
        for (i = 0; i < n; i++) begin
            pix_pending.push_back(make_pixel(mode));
            pixels_queued++;
        end
    endtask

    // register write while the block is idle; the mirror follows at once
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_FRAME_WIDTH: begin
                frame_w_reg = data[CFG_WIDTH_W-1:0];
                next_col    = 0;
                next_row    = 0;
            end
            REG_FRAME_HEIGHT: begin
                frame_h_reg = data[CFG_HGT_W-1:0];
                next_col    = 0;
                next_row    = 0;
            end
            default: ;  // spare indexes leave registers and position alone
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // every queued pixel taken, every owed result seen, then let the pipe settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixels_accepted != pixels_queued || sharpened_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // pixel driver: inputs move on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_xfer) begin
            // channel free: the current pixel went through or none was offered
            if (pix_gap > 0) begin
                pix_ch.valid <= 1'b0;
                pix_gap--;
            end else if (pix_pending.size() != 0) begin
                drive_px = pix_pending.pop_front();
                pix_ch.in_blue  <= drive_px.blue;
                pix_ch.in_green <= drive_px.green;
                pix_ch.in_red   <= drive_px.red;
                pix_ch.valid    <= 1'b1;
                pix_gap = idle_on ? gap_len() : 0;
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: random stalls, some of them long enough to back up the queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (res_stall > 0) begin
            res_ch.ready <= 1'b0;
            res_stall--;
        end else begin
            res_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) res_stall = 1 + gap_len();
        end
    end

    // ------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_xfer <= 1'b0;
        end else begin
            pix_xfer <= pix_ch.valid && pix_ch.ready;
            // predict before checking so an owed result is always queued first
            if (pix_ch.valid && pix_ch.ready) begin
                seen_px.blue  = pix_ch.in_blue;
                seen_px.green = pix_ch.in_green;
                seen_px.red   = pix_ch.in_red;
                sharpen_step(seen_px);
                pixels_accepted <= pixels_accepted + 1;
            end
            if (res_ch.valid && res_ch.ready) check_result();
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int                    i;
        int                    spent;
        int                    pick;
        int                    n;
        int unsigned           w_eff;
        int unsigned           h_eff;
        bit                    big_done;
        t_pix_mode             mode;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;

        // every input known from time zero
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_FRAME_WIDTH;
        i_cfg_data      = '0;
        pix_ch.valid    = 1'b0;
        pix_ch.in_blue  = '0;
        pix_ch.in_green = '0;
        pix_ch.in_red   = '0;
        res_ch.ready    = 1'b0;
        idle_on         = 1'b1;
        for (i = 0; i < 3; i++) smooth_lvl[i] = 128;

        // mirror starts from the reset state
        frame_w_reg = RESET_FRAME_WIDTH;
        frame_h_reg = RESET_FRAME_HEIGHT;
        win_regs    = '0;
        next_col    = 0;
        next_row    = 0;
        for (i = 0; i < 2 * MAX_WIDTH; i++) row_mem[i] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame size: top row copies straight through
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hAA, 8'h55, 8'h0F);
        push_pixel(8'hF0, 8'h0F, 8'h5A);
        wait_idle();

        // 4x3 frame with two interior pixels; ignored upper width bits set
        write_reg(REG_FRAME_WIDTH, 16'hF004);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        for (i = 0; i < 12; i++) begin
            if (i == 5) push_pixel(8'hFF, 8'hFF, 8'hFF);       // clamps high
            else if (i == 6) push_pixel(8'h10, 8'h80, 8'hFF);  // mixed clamps
            else push_pixel(8'h00, 8'h00, 8'h00);
        end
        wait_idle();

        // zero width and height act as a 1x1 frame, wrapping on every pixel
        write_reg(REG_FRAME_WIDTH, 16'h0000);
        write_reg(REG_FRAME_HEIGHT, 16'h0000);
        push_pixel(8'h81, 8'h7E, 8'h01);
        push_pixel(8'h7F, 8'h80, 8'hFE);
        wait_idle();

        // spare index writes in mid-frame must not restart the frame
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        push_pixel(8'h01, 8'h02, 8'h04);
        push_pixel(8'h08, 8'h10, 8'h20);
        push_pixel(8'h40, 8'h80, 8'hC3);
        wait_idle();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        push_pixel(8'h3C, 8'hA5, 8'h5A);
        push_pixel(8'hFE, 8'h01, 8'h7F);
        push_pixel(8'h00, 8'hFF, 8'h00);
        wait_idle();

        // random phases, mostly small frames; one saturated-width frame in the middle
        spent    = 0;
        big_done = 1'b0;
        while (spent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            mode    = t_pix_mode'($urandom_range(0, 2));
            pick    = $urandom_range(0, 9);
            if (!big_done && spent >= RANDOM_ITEMS / 2) begin
                // width above the line store size saturates to it
                w_data = 16'hFFFF;
                h_data = 16'd3;
            end else if (pick <= 5) begin
                w_data = {4'($urandom_range(0, 15)), 12'($urandom_range(1, 12))};
                h_data = 16'($urandom_range(1, 8));
            end else if (pick == 6) begin
                w_data = 16'($urandom_range(13, 70));
                h_data = 16'($urandom_range(3, 5));
            end else if (pick == 7) begin
                // tall frames, mostly only partly filled
                w_data = 16'($urandom_range(3, 8));
                h_data = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(9, 65535));
            end else if (pick == 8) begin
                w_data = {4'($urandom_range(0, 15)), 12'h000};
                h_data = 16'($urandom_range(1, 20));
            end else begin
                w_data = 16'($urandom_range(1, 3));
                h_data = 16'h0000;
            end

            // both orders, and sometimes only the width
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(REG_FRAME_HEIGHT, h_data);
                    write_reg(REG_FRAME_WIDTH, w_data);
                end
                1: write_reg(REG_FRAME_WIDTH, w_data);
                default: begin
                    write_reg(REG_FRAME_WIDTH, w_data);
                    write_reg(REG_FRAME_HEIGHT, h_data);
                end
            endcase
            w_eff = eff_width();
            h_eff = eff_height();

            if (!big_done && spent >= RANDOM_ITEMS / 2) begin
                // part of the top row only, the column must not wrap early
                n        = $urandom_range(150, 250);
                big_done = 1'b1;
            end else begin
                if (h_eff > 10) n = w_eff * $urandom_range(3, 10);
                else n = w_eff * h_eff * $urandom_range(1, 3);
                // a partial row leaves the frame open for the next register write
                n = n + $urandom_range(0, w_eff);
            end
            // keep the total pixel count near the budget
            if (n > RANDOM_ITEMS - spent) n = RANDOM_ITEMS - spent;
            spent = spent + n;
            queue_pixels(n, mode);
            wait_idle();
        end

        // nothing owed any more; a stray result in this window still fails
        repeat (4 * DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
src/rsh_pkg.sv
src/rsh_ifs.sv
src/rsh_ram.sv
src/rsh_sharpen.sv
src/rgb_sharpen_3x3_stream_unit.sv
tb/sv/rgb_sharpen_3x3_stream_unit_tb.sv
